FILE: src/bpc_pkg.sv
package bpc_pkg;

    localparam int TIME_W     = 32;
    localparam int LONG_W     = 16;
    localparam int LOCKOUT_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int EVT_W      = 2;

    localparam logic [LONG_W-1:0]    LONG_PRESS_RST = LONG_W'(1000);
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RST    = LOCKOUT_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_PRESS = 1'b0,
        REG_LOCKOUT    = 1'b1
    } t_cfg_reg;

    typedef enum logic [EVT_W-1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } t_press_event;

endpackage

FILE: src/button_short_long_press_classifier_unit.sv
// Classifies polls of an active-low push button into short and long presses.
// Every poll beat returns exactly one event beat: none, short press released,
// or long press reached. A poll is acted on only once more than the lockout
// time has passed since the last recorded edge. The block takes one poll per
// cycle unless stalled, moving it from input register to event register; the
// state update is a pair of 32-bit subtract-and-compare paths between them,
// so a back-to-back poll always sees the state left by the one before.
// Input stall rises only while the event register is full and stalled.
module button_short_long_press_classifier_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [bpc_pkg::TIME_W-1:0]         i_now_ms,
    input  logic                               i_pin_level,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [bpc_pkg::EVT_W-1:0]          o_press_event,
    input  logic                               i_cfg_wr_en,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bpc_pkg::*;

    logic [LONG_W-1:0]    r_long_press_ms;
    logic [LOCKOUT_W-1:0] r_lockout_ms;

    logic                 r_in_valid;
    logic [TIME_W-1:0]    r_now;
    logic                 r_lvl;

    logic                 r_last_level;
    logic [TIME_W-1:0]    r_lockout_start;
    logic [TIME_W-1:0]    r_press_start;
    logic                 r_armed;

    logic                 r_out_valid;
    t_press_event         r_event;

    logic                 n_last_level;
    logic [TIME_W-1:0]    n_lockout_start;
    logic [TIME_W-1:0]    n_press_start;
    logic                 n_armed;
    t_press_event         n_event;

    logic                 out_free;
    logic                 take_in;
    logic                 move;
    logic                 act;
    logic                 fall;
    logic                 rise;
    logic                 armed_mid;
    logic                 long_hit;
    logic [TIME_W-1:0]    press_mid;
    logic [TIME_W-1:0]    since_edge;
    logic [TIME_W-1:0]    held;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign move       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign take_in    = i_in_valid && !o_in_stall;

    assign o_out_valid   = r_out_valid;
    assign o_press_event = r_event;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press_ms <= LONG_PRESS_RST;
            r_lockout_ms    <= LOCKOUT_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_LONG_PRESS: r_long_press_ms <= i_cfg_data[LONG_W-1:0];
                REG_LOCKOUT:    r_lockout_ms    <= i_cfg_data[LOCKOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // poll input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_now <= i_now_ms;
            r_lvl <= i_pin_level;
        end
    end

    // classification, all differences modulo 2^32
    always_comb begin
        since_edge = r_now - r_lockout_start;
        act        = since_edge > {{(TIME_W-LOCKOUT_W){1'b0}}, r_lockout_ms};
        fall       = !r_lvl && r_last_level;
        rise       = r_lvl && !r_last_level;
        armed_mid  = fall || r_armed;
        press_mid  = fall ? r_now : r_press_start;
        held       = r_now - press_mid;
        long_hit   = armed_mid && (held > {{(TIME_W-LONG_W){1'b0}}, r_long_press_ms});

        n_last_level    = r_last_level;
        n_lockout_start = r_lockout_start;
        n_press_start   = r_press_start;
        n_armed         = r_armed;
        n_event         = EVT_NONE;
        if (act) begin
            n_last_level  = r_lvl;
            n_press_start = press_mid;
            n_armed       = armed_mid && !long_hit && !rise;
            if (fall || rise) begin
                n_lockout_start = r_now;
            end
            if (long_hit) begin
                n_event = EVT_LONG;
            end else if (rise && armed_mid) begin
                n_event = EVT_SHORT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level    <= 1'b0;
            r_lockout_start <= '0;
            r_press_start   <= '0;
            r_armed         <= 1'b0;
        end else if (move) begin
            r_last_level    <= n_last_level;
            r_lockout_start <= n_lockout_start;
            r_press_start   <= n_press_start;
            r_armed         <= n_armed;
        end
    end

    // event register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_event <= n_event;
        end
    end

    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a stalled event beat");

    a_short_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && n_event == EVT_SHORT) |-> r_armed)
        else $error("short press reported while not armed");

    a_release_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && act && rise) |=> !r_armed)
        else $error("release left detector armed");

    a_lockout_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && !act) |=> ($stable(r_last_level) && $stable(r_armed)
                            && $stable(r_lockout_start)))
        else $error("poll inside lockout changed state");

endmodule

FILE: tb/button_short_long_press_classifier_unit_tb.sv
`timescale 1ns / 100ps

module button_short_long_press_classifier_unit_tb;
    import bpc_pkg::*;

    typedef struct {
        logic [TIME_W-1:0] ms;
        logic              level;
        int unsigned       gap;
    } t_poll;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    logic [TIME_W-1:0]      i_now_ms    = '0;
    logic                   i_pin_level = 1'b1;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [EVT_W-1:0]       o_press_event;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = REG_LONG_PRESS;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // predictor state and its copy of the registers
    logic [LONG_W-1:0]      long_cfg    = LONG_PRESS_RST;
    logic [LOCKOUT_W-1:0]   lockout_cfg = LOCKOUT_RST;
    logic                   level_prev  = 1'b0;
    logic [TIME_W-1:0]      lock_ref_ms = '0;
    logic [TIME_W-1:0]      press_ms    = '0;
    logic                   armed       = 1'b0;

    t_press_event           expected_events[$];
    t_poll                  pending_polls[$];
    t_poll                  held;
    bit                     holding     = 1'b0;
    bit                     poll_taken  = 1'b0;
    int unsigned            polls_queued = 0;
    int unsigned            polls_taken  = 0;
    int unsigned            mismatches   = 0;
    int unsigned            stall_left   = 0;
    int unsigned            stall_max    = 9;
    bit                     sender_idle  = 1'b1;

    // stimulus view of the registers and of time
    int unsigned            long_s = 1000;
    int unsigned            lock_s = 50;
    logic [TIME_W-1:0]      t_ms   = '0;

    button_short_long_press_classifier_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_now_ms      (i_now_ms),
        .i_pin_level   (i_pin_level),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_press_event (o_press_event),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_press_event classify_poll(logic [TIME_W-1:0] poll_ms, logic level);
        t_press_event      ev;
        logic [TIME_W-1:0] since_edge;
        logic [TIME_W-1:0] held_for;
        logic              fall;
        logic              rise;
        ev = EVT_NONE;
        since_edge = poll_ms - lock_ref_ms;
        if (since_edge > {{(TIME_W-LOCKOUT_W){1'b0}}, lockout_cfg}) begin
            fall = !level && level_prev;
            rise = level && !level_prev;
            if (fall) begin
                lock_ref_ms = poll_ms;
                press_ms    = poll_ms;
                armed       = 1'b1;
            end
            held_for = poll_ms - press_ms;
            if (armed && held_for > {{(TIME_W-LONG_W){1'b0}}, long_cfg}) begin
                armed = 1'b0;
                ev    = EVT_LONG;
            end
            if (rise) begin
                lock_ref_ms = poll_ms;
                if (armed)
                    ev = EVT_SHORT;
                armed = 1'b0;
            end
            level_prev = level;
        end
        return ev;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_poll(logic [TIME_W-1:0] poll_ms, logic level);
        t_poll p;
        p.ms    = poll_ms;
        p.level = level;
        p.gap   = sender_idle ? $urandom_range(0, 9) : 0;
        pending_polls.push_back(p);
        polls_queued++;
    endtask

    // wait until every queued poll is taken and every event checked
    task automatic drain();
        do
            @(negedge i_clk);
        while (polls_taken != polls_queued || expected_events.size() != 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic set_config(int unsigned long_ms, int unsigned lock_ms);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_LONG_PRESS;
        i_cfg_data  <= CFG_DATA_W'(long_ms);
        @(negedge i_clk);
        i_cfg_index <= REG_LOCKOUT;
        // upper data bits are don't-care for the lockout register
        i_cfg_data  <= {8'($urandom), 8'(lock_ms)};
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        long_s = long_ms;
        lock_s = lock_ms;
    endtask

    // release, press with some bounce, hold, release
    task automatic press_cycle();
        logic [TIME_W-1:0] p;
        int unsigned       hold;
        int unsigned       k;
        int unsigned       mode;
        t_ms = t_ms + lock_s + 1 + $urandom_range(0, 3);
        add_poll(t_ms, 1'b1);
        t_ms = t_ms + lock_s + 1 + $urandom_range(0, 2);
        add_poll(t_ms, 1'b0);
        p = t_ms;
        repeat ($urandom_range(0, 2))
            add_poll(p + $urandom_range(0, lock_s), 1'($urandom_range(0, 1)));
        mode = $urandom_range(0, 3);
        case (mode)
            0: hold = $urandom_range(0, long_s);
            1: hold = long_s + $urandom_range(0, 1);
            2: hold = long_s + 1 + $urandom_range(0, 3000);
            default: hold = $urandom_range(0, lock_s + 2);
        endcase
        k = $urandom_range(0, 3);
        for (int unsigned i = 1; i <= k; i++)
            add_poll(p + (hold * i) / (k + 1), 1'b0);
        if (mode == 1 || mode == 2) begin
            add_poll(p + long_s, 1'b0);
            add_poll(p + long_s + 1, 1'b0);
        end
        t_ms = p + hold;
        add_poll(t_ms, 1'b1);
    endtask

    always @(negedge i_clk) begin : poll_driver
        if (i_rst_n && (!i_in_valid || poll_taken)) begin
            if (!holding && pending_polls.size() != 0) begin
                held = pending_polls.pop_front();
                holding = 1'b1;
            end
            if (holding && held.gap == 0) begin
                i_in_valid  <= 1'b1;
                i_now_ms    <= held.ms;
                i_pin_level <= held.level;
                holding = 1'b0;
            end else begin
                i_in_valid <= 1'b0;
                if (holding)
                    held.gap = held.gap - 1;
            end
        end
        poll_taken = 1'b0;
    end

    always @(negedge i_clk) begin : event_sink
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : event_monitor
        t_press_event want;
        if (i_rst_n) begin
            // check the outgoing beat first: it can never belong to this edge's poll
            if (o_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("event beat %0d with nothing pending",
                                              o_press_event));
                end else begin
                    want = expected_events.pop_front();
                    if (o_press_event !== want)
                        report_mismatch($sformatf("press_event %0d, expected %0d (%s)",
                                                  o_press_event, want, want.name()));
                end
                stall_left = $urandom_range(0, stall_max);
            end
            if (i_in_valid && !o_in_stall) begin
                expected_events.push_back(classify_poll(i_now_ms, i_pin_level));
                poll_taken = 1'b1;
                polls_taken++;
            end
            if (i_cfg_wr_en) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_LONG_PRESS: long_cfg    = i_cfg_data[LONG_W-1:0];
                    REG_LOCKOUT:    lockout_cfg = i_cfg_data[LOCKOUT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    initial begin : stimulus
        int unsigned target;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: long 1000, lockout 50
        add_poll(32'd0, 1'b1);              // inside the lockout after reset
        add_poll(32'd50, 1'b1);
        add_poll(32'd51, 1'b1);             // first release edge, nothing armed
        add_poll(32'd101, 1'b0);            // still locked out
        add_poll(32'd102, 1'b0);            // press
        add_poll(32'd120, 1'b1);            // bounce, ignored
        add_poll(32'd1102, 1'b0);           // exactly the long time, not beyond
        add_poll(32'd1103, 1'b0);           // long press
        add_poll(32'd1200, 1'b1);           // release after long, no event
        add_poll(32'd1300, 1'b0);
        add_poll(32'd1400, 1'b1);           // short press
        add_poll(32'hFFFF_FFF0, 1'b0);      // press just before the wrap
        add_poll(32'h0000_0010, 1'b1);      // locked out across the wrap
        add_poll(32'h0000_0100, 1'b1);      // short press across the wrap
        add_poll(32'h0000_0080, 1'b0);      // time going backwards
        add_poll(32'h0000_0080 + 32'd1001, 1'b0);
        add_poll(32'hFFFF_FFFF, 1'b1);
        add_poll(32'h0000_0000, 1'b0);      // one ms later, locked out
        add_poll(32'h0000_0033, 1'b0);      // press; hold is zero on this poll
        add_poll(32'h0000_0033 + 32'd500, 1'b1);
        add_poll(32'hAAAA_5555, 1'b1);
        add_poll(32'h5555_AAAA, 1'b0);
        add_poll(32'h5555_AAAA + 32'd20000, 1'b0);

        for (int unsigned phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: set_config(1000, 50);
                1: set_config(0, 0);
                2: set_config(65535, 255);
                3: set_config($urandom_range(0, 65535), $urandom_range(0, 255));
                4: set_config($urandom_range(0, 300), $urandom_range(0, 20));
                default: set_config($urandom_range(0, 100), $urandom_range(150, 255));
            endcase
            sender_idle = (phase != 2);
            stall_max   = (phase == 2 || phase == 4) ? 0 : 9;
            t_ms = $urandom;
            target = polls_queued + 270;
            while (polls_queued < target) begin
                if ($urandom_range(0, 99) < 85) begin
                    press_cycle();
                end else begin
                    repeat ($urandom_range(1, 3))
                        add_poll($urandom, 1'($urandom_range(0, 1)));
                    if ($urandom_range(0, 1) != 0)
                        t_ms = $urandom;
                end
            end
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("button_short_long_press_classifier_unit_tb OK");
        end else begin
            $display("button_short_long_press_classifier_unit_tb NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("button_short_long_press_classifier_unit_tb NOT OK");
        $finish;
    end

endmodule
